/* rtl/first_fit_block_allocator_core_assert.svh */
// ---------------------------------------------------------------------------
// first_fit_block_allocator_core_assert
// assertion macros used by the allocator core
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define FFBA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ffba assertion failed");

// next-cycle implication, checked out of reset
`define FFBA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ffba assertion failed");

`endif

/* rtl/ffba_pkg.sv */
// ---------------------------------------------------------------------------
// ffba_pkg
// constants and types of the first-fit block allocator
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ffba_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int BLOCK_BYTES   = 4096;
    localparam int BLOCK_SHIFT   = $clog2(BLOCK_BYTES);

    localparam int TBL_AW  = $clog2(TABLE_ENTRIES);   // table address bits
    localparam int CNT_W   = TBL_AW + 1;              // holds TABLE_ENTRIES itself
    localparam int ADDR_W  = 32;
    localparam int BYTES_W = 32;
    localparam int USE_W   = 11;                      // blocks_in_use register
    localparam int START_W = 10;                      // start_block field
    localparam int NEED_W  = BYTES_W + 1 - BLOCK_SHIFT;
    localparam int ENT_W   = 3;

    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 32;
    localparam int OUT_W     = 48;                    // 43 field bits padded to bytes

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_USED = CFG_IDX_W'(1);

    // table entry bits
    localparam logic [ENT_W-1:0] ENT_TAKEN     = 3'b001;
    localparam logic [ENT_W-1:0] ENT_FIRST     = 3'b010;
    localparam logic [ENT_W-1:0] ENT_HAS_NEXT  = 3'b100;
    localparam logic [ENT_W-1:0] ENT_TYPE_MASK = ENT_W'(8'h0f);
    localparam logic [ENT_W-1:0] ENT_FREE      = '0;

    typedef struct packed {
        logic               valid;
        logic [BYTES_W-1:0] bytes;
        logic [CNT_W-1:0]   usable;
    } t_ffba_req;

    typedef struct packed {
        logic               valid;
        logic               ok;
        logic [TBL_AW-1:0]  start;
    } t_ffba_res;

    typedef struct packed {
        logic idle;
        logic clearing;
    } t_ffba_stat;

    typedef struct packed {
        logic              we;
        logic [TBL_AW-1:0] waddr;
        logic [ENT_W-1:0]  wdata;
        logic [TBL_AW-1:0] raddr;
    } t_ffba_mem;

endpackage

/* rtl/ffba_table.sv */
// ---------------------------------------------------------------------------
// ffba_table
// block table memory, one write and one registered read per cycle
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffba_table (
    input  logic                          i_clk,
    input  ffba_pkg::t_ffba_mem           i_mem,
    output logic [ffba_pkg::ENT_W-1:0]    o_rd_data
);
    import ffba_pkg::*;

    logic [ENT_W-1:0] r_mem [TABLE_ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_mem.we) begin
            r_mem[i_mem.waddr] <= i_mem.wdata;
        end
        o_rd_data <= r_mem[i_mem.raddr];
    end

endmodule

/* rtl/ffba_seq.sv */
// ---------------------------------------------------------------------------
// ffba_seq
// sequencer: table clear, first-fit scan and run marking
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffba_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ffba_pkg::t_ffba_req           i_req,
    input  logic                          i_res_ack,
    input  logic [ffba_pkg::ENT_W-1:0]    i_rd_data,
    output ffba_pkg::t_ffba_stat          o_stat,
    output ffba_pkg::t_ffba_res           o_res,
    output ffba_pkg::t_ffba_mem           o_mem
);
    import ffba_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_DONE
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_iss, n_iss;       // next read address
    logic              r_chk_vld, n_chk_vld;
    logic [TBL_AW-1:0] r_chk_idx, n_chk_idx;
    logic [CNT_W-1:0]  r_cnt, n_cnt;       // free run length so far, also mark offset
    logic [TBL_AW-1:0] r_first, n_first;
    logic [CNT_W-1:0]  r_need, n_need;
    logic [CNT_W-1:0]  r_lim, n_lim;
    logic [TBL_AW-1:0] r_clr, n_clr;
    logic              r_ok, n_ok;

    logic [BYTES_W:0]  w_sum;
    logic [NEED_W-1:0] w_need;
    logic [TBL_AW-1:0] w_run_first;
    logic [CNT_W-1:0]  w_cnt_inc;

    // round up to whole blocks without wrapping
    assign w_sum       = {1'b0, i_req.bytes} + (BYTES_W + 1)'(BLOCK_BYTES - 1);
    assign w_need      = w_sum[BYTES_W:BLOCK_SHIFT];
    assign w_run_first = (r_cnt == '0) ? r_chk_idx : r_first;
    assign w_cnt_inc   = r_cnt + CNT_W'(1);

    always_comb begin
        n_state   = r_state;
        n_iss     = r_iss;
        n_chk_vld = 1'b0;
        n_chk_idx = r_chk_idx;
        n_cnt     = r_cnt;
        n_first   = r_first;
        n_need    = r_need;
        n_lim     = r_lim;
        n_clr     = r_clr;
        n_ok      = r_ok;

        o_mem.we    = 1'b0;
        o_mem.waddr = r_clr;
        o_mem.wdata = ENT_FREE;
        o_mem.raddr = r_iss[TBL_AW-1:0];

        unique case (r_state)
            S_CLEAR: begin
                o_mem.we = 1'b1;
                n_clr    = r_clr + TBL_AW'(1);
                if (r_clr == TBL_AW'(TABLE_ENTRIES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_iss   = '0;
                    n_cnt   = '0;
                    n_lim   = i_req.usable;
                    n_need  = CNT_W'(w_need);
                    n_first = '0;
                    if (w_need == '0 || w_need > NEED_W'(i_req.usable)) begin
                        n_ok    = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_iss < r_lim) begin
                    n_iss     = r_iss + CNT_W'(1);
                    n_chk_vld = 1'b1;
                    n_chk_idx = r_iss[TBL_AW-1:0];
                end
                if (r_chk_vld) begin
                    if ((i_rd_data & ENT_TYPE_MASK) != ENT_FREE) begin
                        n_cnt = '0;
                    end else begin
                        n_first = w_run_first;
                        n_cnt   = w_cnt_inc;
                    end
                    if ((i_rd_data & ENT_TYPE_MASK) == ENT_FREE && w_cnt_inc == r_need) begin
                        n_cnt     = '0;
                        n_chk_vld = 1'b0;
                        n_state   = S_MARK;
                    end else if ({1'b0, r_chk_idx} + CNT_W'(1) == r_lim) begin
                        n_ok    = 1'b0;
                        n_first = '0;
                        n_state = S_DONE;
                    end
                end
            end
            S_MARK: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_first + r_cnt[TBL_AW-1:0];
                o_mem.wdata = ENT_TAKEN
                            | ((r_cnt == '0) ? ENT_FIRST : ENT_FREE)
                            | ((w_cnt_inc < r_need) ? ENT_HAS_NEXT : ENT_FREE);
                n_cnt = w_cnt_inc;
                if (w_cnt_inc == r_need) begin
                    n_ok    = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ack) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_chk_vld <= 1'b0;
            r_iss     <= '0;
            r_cnt     <= '0;
            r_ok      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_chk_vld <= n_chk_vld;
            r_iss     <= n_iss;
            r_cnt     <= n_cnt;
            r_ok      <= n_ok;
        end
        r_chk_idx <= n_chk_idx;
        r_first   <= n_first;
        r_need    <= n_need;
        r_lim     <= n_lim;
    end

    assign o_stat.idle     = (r_state == S_IDLE);
    assign o_stat.clearing = (r_state == S_CLEAR);
    assign o_res.valid     = (r_state == S_DONE);
    assign o_res.ok        = r_ok;
    assign o_res.start     = r_ok ? r_first : '0;

endmodule

/* rtl/first_fit_block_allocator_core.sv */
// ---------------------------------------------------------------------------
// first_fit_block_allocator_core
// first-fit allocator over a table of fixed-size heap blocks
// ---------------------------------------------------------------------------
// Each beat on the slave side is a request in bytes; it is rounded up to whole
// 4096-byte blocks and the block table (1024 entries) is scanned from entry 0
// for the first run of that many free entries among the first blocks_in_use
// entries (capped at 1024). A found run is marked taken and one result beat
// returns ok, heap base plus start block times block size, and the start
// block; a zero-byte request or one with no room returns ok=0 with zeros and
// leaves the table as it was. After reset a clearing pass writes every table
// entry once, during which no request is taken (config writes are always
// taken). A request that fails on size alone goes straight to its result;
// otherwise the scan reads one entry per cycle through the table's single read
// port, then one write per block marks the run, and the result waits until the
// output register can take it. One request is worked at a time; a new one
// is taken while the previous result still waits on the master side.
// Config writes are only legal while no request is in flight.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "first_fit_block_allocator_core_assert.svh"

module first_fit_block_allocator_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request side
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [ffba_pkg::BYTES_W-1:0]      i_s_axis_tdata,   // [31:0] request_bytes
    // result side
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [ffba_pkg::OUT_W-1:0]        o_m_axis_tdata,   // [0] ok, [32:1] block_address,
                                                                // [42:33] first block index,
                                                                // rest 0
    // config write
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ffba_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ffba_pkg::CFG_DAT_W-1:0]    i_cfg_data
);
    import ffba_pkg::*;

    // config registers
    logic [ADDR_W-1:0] r_heap_base;
    logic [USE_W-1:0]  r_blocks_used;
    logic [CNT_W-1:0]  w_usable;

    // output register
    logic              r_out_valid;
    logic              r_out_ok;
    logic [ADDR_W-1:0] r_out_addr;
    logic [START_W-1:0] r_out_start;

    t_ffba_req         w_req;
    t_ffba_res         w_res;
    t_ffba_stat        w_stat;
    t_ffba_mem         w_mem;
    logic [ENT_W-1:0]  w_rd_data;
    logic              w_res_ack;
    logic [ADDR_W-1:0] w_offset;

    // blocks_in_use saturates at the table size
    assign w_usable = (r_blocks_used > USE_W'(TABLE_ENTRIES)) ? CNT_W'(TABLE_ENTRIES)
                                                             : CNT_W'(r_blocks_used);

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = w_stat.idle;

    assign w_req.valid  = i_s_axis_tvalid && w_stat.idle;
    assign w_req.bytes  = i_s_axis_tdata;
    assign w_req.usable = w_usable;

    // result moves into the output register when it is empty or draining
    assign w_res_ack = !r_out_valid || i_m_axis_tready;
    assign w_offset  = ADDR_W'(w_res.start) << BLOCK_SHIFT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base   <= '0;
            r_blocks_used <= USE_W'(TABLE_ENTRIES);
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_HEAP_BASE:   r_heap_base   <= i_cfg_data;
                    REG_BLOCKS_USED: r_blocks_used <= i_cfg_data[USE_W-1:0];
                    default: ;   // unknown index, write dropped
                endcase
            end
            if (w_res.valid && w_res_ack) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_res.valid && w_res_ack) begin
            r_out_ok    <= w_res.ok;
            r_out_addr  <= w_res.ok ? (r_heap_base + w_offset) : '0;
            r_out_start <= START_W'(w_res.start);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'b0, r_out_start, r_out_addr, r_out_ok};

    ffba_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req),
        .i_res_ack (w_res_ack),
        .i_rd_data (w_rd_data),
        .o_stat    (w_stat),
        .o_res     (w_res),
        .o_mem     (w_mem)
    );

    ffba_table u_table (
        .i_clk     (i_clk),
        .i_mem     (w_mem),
        .o_rd_data (w_rd_data)
    );

    // a failed result carries zero address and zero start block
    `FFBA_ASSERT_IMP(a_fail_zero, o_m_axis_tvalid && !o_m_axis_tdata[0], o_m_axis_tdata[42:1] == '0)
    // no request is taken while the table is being cleared
    `FFBA_ASSERT_IMP(a_clear_blocks, w_stat.clearing, !o_s_axis_tready)
    // a handed-off result shows up on the master side next cycle
    `FFBA_ASSERT_NXT(a_res_load, w_res.valid && w_res_ack, o_m_axis_tvalid)
    // a granted run starts inside the usable part of the table
    `FFBA_ASSERT_IMP(a_start_range, w_res.valid && w_res.ok, CNT_W'(w_res.start) < w_usable)

endmodule

/* bench/first_fit_block_allocator_core_tb.sv */
// ---------------------------------------------------------------------------
// first_fit_block_allocator_core_tb
// self-checking bench for the first-fit block allocator
// ---------------------------------------------------------------------------
// A queue of pending operations (requests, register writes and idle points)
// feeds a clocked driver. Every accepted request is run through a shadow copy
// of the block table and configuration, and the predicted grant is queued. A
// clocked monitor pops one prediction per result beat and compares each
// field. Both sides idle in random bursts except in short calm stretches and near the end of the run.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module first_fit_block_allocator_core_tb;

    import ffba_pkg::*;

    localparam int SETTLE_CYCLES = 4;      // quiet cycles after an idle point
    localparam int CALM_TAIL     = 40;     // no idling once this few ops remain
    localparam int END_CYCLES    = 16;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 36;

    // index with no register behind it, writes must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = '1;

    typedef enum logic [1:0] {
        OP_REQUEST,
        OP_REG_WRITE,
        OP_WAIT_IDLE
    } t_op_kind;

    typedef struct packed {
        t_op_kind               kind;
        logic [CFG_IDX_W-1:0]   index;
        logic [CFG_DAT_W-1:0]   data;
    } t_pending_op;

    typedef struct packed {
        logic                 ok;
        logic [ADDR_W-1:0]    address;
        logic [START_W-1:0]   first_blk;
    } t_alloc_result;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;

    logic                   req_valid = 1'b0;
    logic [BYTES_W-1:0]     req_bytes = '0;
    logic                   o_s_axis_tready;
    logic                   o_m_axis_tvalid;
    logic                   res_ready = 1'b0;
    logic [OUT_W-1:0]       o_m_axis_tdata;
    logic                   cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DAT_W-1:0]   cfg_data = '0;
    logic                   o_cfg_ready;

    t_pending_op            pending_ops[$];
    t_alloc_result          expected_grants[$];

    // shadow state of the allocator
    logic [ENT_W-1:0]       shadow_table[TABLE_ENTRIES];
    logic [ADDR_W-1:0]      shadow_heap_base = '0;
    logic [USE_W-1:0]       shadow_blocks_used = USE_W'(TABLE_ENTRIES);

    int unsigned            gap_left = 0;
    int unsigned            settle_left = SETTLE_CYCLES;
    int unsigned            stall_left = 0;
    int unsigned            n_requests = 0;
    int unsigned            n_granted = 0;
    int unsigned            n_refused = 0;
    int unsigned            n_reg_writes = 0;
    int unsigned            n_errors = 0;

    first_fit_block_allocator_core u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (req_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (req_bytes),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (res_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    task automatic push_request(input logic [BYTES_W-1:0] bytes);
        pending_ops.push_back('{OP_REQUEST, '0, bytes});
    endtask

    task automatic push_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DAT_W-1:0] value);
        pending_ops.push_back('{OP_REG_WRITE, idx, value});
    endtask

    task automatic push_wait_idle();
        pending_ops.push_back('{OP_WAIT_IDLE, '0, '0});
    endtask

    // random idling is off in the tail and in short calm stretches
    function automatic logic idling_allowed();
        return pending_ops.size() >= CALM_TAIL && (pending_ops.size() % 50) >= 10;
    endfunction

    // first-fit search over the shadow table; marks the run on success
    function automatic t_alloc_result allocate_first_fit(input logic [BYTES_W-1:0] bytes);
        t_alloc_result      res;
        logic [BYTES_W:0]   blocks_needed;
        int unsigned        usable;
        int unsigned        run_len;
        int unsigned        run_start;
        logic               found;
        logic [ENT_W-1:0]   entry;
        res = '0;
        // round up without wrapping, so huge requests just miss
        blocks_needed = ({1'b0, bytes} + (BLOCK_BYTES - 1)) >> BLOCK_SHIFT;
        usable = (shadow_blocks_used > TABLE_ENTRIES) ? TABLE_ENTRIES : shadow_blocks_used;
        if (blocks_needed == 0 || blocks_needed > usable)
            return res;
        found = 1'b0;
        run_len = 0;
        run_start = 0;
        for (int i = 0; i < usable && !found; i++) begin
            if ((shadow_table[i] & ENT_TYPE_MASK) != ENT_FREE) begin
                run_len = 0;
            end else begin
                if (run_len == 0)
                    run_start = i;
                run_len++;
                if (run_len == blocks_needed)
                    found = 1'b1;
            end
        end
        if (!found)
            return res;
        // head gets first, every block but the tail gets has-next
        for (int k = 0; k < blocks_needed; k++) begin
            entry = ENT_TAKEN;
            if (k == 0)
                entry = entry | ENT_FIRST;
            if (k + 1 < blocks_needed)
                entry = entry | ENT_HAS_NEXT;
            shadow_table[run_start + k] = entry;
        end
        res.ok = 1'b1;
        res.address = shadow_heap_base + (ADDR_W'(run_start) << BLOCK_SHIFT);
        res.first_blk = START_W'(run_start);
        return res;
    endfunction

    // driver: request and config channels, fed from pending_ops
    always @(posedge clk) begin : drive_side
        logic        req_beat;
        logic        cfg_beat;
        logic        nxt_req_valid;
        logic        nxt_cfg_valid;
        t_pending_op op;
        if (!rst_n) begin
            req_valid <= 1'b0;
            cfg_valid <= 1'b0;
            gap_left = 0;
            settle_left = SETTLE_CYCLES;
        end else begin
            req_beat = req_valid && o_s_axis_tready;
            cfg_beat = cfg_valid && o_cfg_ready;
            if (req_beat) begin
                expected_grants.push_back(allocate_first_fit(req_bytes));
                n_requests++;
            end
            if (cfg_beat) begin
                case (cfg_index)
                    REG_HEAP_BASE:   shadow_heap_base = cfg_data;
                    REG_BLOCKS_USED: shadow_blocks_used = cfg_data[USE_W-1:0];
                    default: ;       // unmapped index, dropped
                endcase
                n_reg_writes++;
            end
            nxt_req_valid = req_valid && !req_beat;
            nxt_cfg_valid = cfg_valid && !cfg_beat;
            if (!nxt_req_valid && !nxt_cfg_valid) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (pending_ops.size() != 0) begin
                    op = pending_ops[0];
                    case (op.kind)
                        OP_REQUEST: begin
                            nxt_req_valid = 1'b1;
                            req_bytes <= op.data;
                            void'(pending_ops.pop_front());
                        end
                        OP_REG_WRITE: begin
                            nxt_cfg_valid = 1'b1;
                            cfg_index <= op.index;
                            cfg_data <= op.data;
                            void'(pending_ops.pop_front());
                        end
                        OP_WAIT_IDLE: begin
                            // hold off until every grant is back, then settle
                            if (expected_grants.size() == 0) begin
                                if (settle_left == 0) begin
                                    settle_left = SETTLE_CYCLES;
                                    void'(pending_ops.pop_front());
                                end else begin
                                    settle_left--;
                                end
                            end
                        end
                        default: ;
                    endcase
                    if (op.kind != OP_WAIT_IDLE && idling_allowed() && $urandom_range(0, 3) == 0)
                        gap_left = $urandom_range(1, 7);
                end
            end
            req_valid <= nxt_req_valid;
            cfg_valid <= nxt_cfg_valid;
        end
    end

    // monitor: result beats checked against the oldest prediction
    always @(posedge clk) begin : check_side
        t_alloc_result   want;
        t_alloc_result   got;
        logic [OUT_W-44:0] pad;
        if (!rst_n) begin
            res_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_m_axis_tvalid && res_ready) begin
                got.ok = o_m_axis_tdata[0];
                got.address = o_m_axis_tdata[32:1];
                got.first_blk = o_m_axis_tdata[42:33];
                pad = o_m_axis_tdata[OUT_W-1:43];
                if (expected_grants.size() == 0) begin
                    $error("result beat with no request outstanding: tdata %h", o_m_axis_tdata);
                    n_errors++;
                end else begin
                    want = expected_grants.pop_front();
                    if (want.ok)
                        n_granted++;
                    else
                        n_refused++;
                    if (got.ok !== want.ok) begin
                        $error("ok: expected %0d, got %0d", want.ok, got.ok);
                        n_errors++;
                    end
                    if (got.address !== want.address) begin
                        $error("block_address: expected %h, got %h", want.address, got.address);
                        n_errors++;
                    end
                    if (got.first_blk !== want.first_blk) begin
                        $error("first block index: expected %0d, got %0d",
                               want.first_blk, got.first_blk);
                        n_errors++;
                    end
                    if (pad !== '0) begin
                        $error("tdata padding: expected 0, got %h", pad);
                        n_errors++;
                    end
                end
            end
            // back-pressure in random bursts
            if (stall_left != 0) begin
                stall_left--;
                res_ready <= 1'b0;
            end else if (idling_allowed() && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 6);
                res_ready <= 1'b0;
            end else begin
                res_ready <= 1'b1;
            end
        end
    end

    initial begin : run_test
        logic [BYTES_W-1:0]   bytes;
        logic [ADDR_W-1:0]    base;
        int unsigned          window;
        int unsigned          pick;
        int unsigned          k;

        for (int i = 0; i < TABLE_ENTRIES; i++)
            shadow_table[i] = ENT_FREE;

        // directed: reset config, base 0 and the full table
        push_request('0);                             // zero bytes refuses
        push_request(1);                              // one byte, block 0
        push_request(BLOCK_BYTES);                    // exact block
        push_request(BLOCK_BYTES + 1);                // one byte over, two-block run
        push_request('1);                             // huge request
        push_request(TABLE_ENTRIES * BLOCK_BYTES);    // whole table, scan misses
        push_wait_idle();

        // small window, base near the top so the address wraps
        push_reg_write(REG_HEAP_BASE, 32'hFFFF_F000);
        push_reg_write(REG_BLOCKS_USED, 8);
        push_request(4 * BLOCK_BYTES);
        push_request(1);                              // window full
        push_wait_idle();

        // no usable blocks at all
        push_reg_write(REG_BLOCKS_USED, 0);
        push_request(1);
        push_request(32'h8000_0000);
        push_wait_idle();

        // upper data bits dropped, unmapped index ignored, unaligned base
        push_reg_write(REG_UNMAPPED, '1);
        push_reg_write(REG_BLOCKS_USED, 32'hFFFF_F80C);
        push_reg_write(REG_HEAP_BASE, '1);
        push_request(12 * BLOCK_BYTES);               // need equals window, no room
        push_request(13 * BLOCK_BYTES);               // need beyond window
        push_request(3 * BLOCK_BYTES);
        push_request(1);                              // fills the last block exactly
        push_request(1);
        window = 12;

        // random phases, each opening a window no smaller than the one before
        for (int phase = 0; phase < PHASES; phase++) begin
            push_wait_idle();
            case (phase)
                0:       base = '0;
                5:       base = $urandom();
                default: base = $urandom() & 32'hFFFF_F000;
            endcase
            if (phase == PHASES - 2)
                window = TABLE_ENTRIES;
            else if (phase == PHASES - 1)
                window = 2047;                        // saturates to the table size
            else
                window = window + $urandom_range(24, 100);
            push_reg_write(REG_HEAP_BASE, base);
            push_reg_write(REG_BLOCKS_USED, CFG_DAT_W'(window));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 19);
                if (pick < 9) begin
                    bytes = $urandom_range(1, 2 * BLOCK_BYTES);
                end else if (pick < 14) begin
                    bytes = $urandom_range(1, 8 * BLOCK_BYTES);
                end else if (pick < 16) begin
                    k = $urandom_range(1, 6);
                    bytes = k * BLOCK_BYTES + $urandom_range(0, 1);
                end else if (pick < 18) begin
                    bytes = $urandom();
                end else if (pick < 19) begin
                    bytes = '0;
                end else begin
                    bytes = BYTES_W'(window * BLOCK_BYTES);
                end
                push_request(bytes);
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() != 0 || req_valid || cfg_valid ||
               expected_grants.size() != 0)
            @(posedge clk);
        repeat (END_CYCLES) @(posedge clk);

        $display("covered %0d requests: %0d granted, %0d refused", n_requests, n_granted,
                 n_refused);
        $display("with %0d register writes across %0d heap windows", n_reg_writes, PHASES + 4);
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // watchdog well above the slowest legal run
    initial begin : watchdog
        #30_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/ffba_pkg.sv
rtl/ffba_table.sv
rtl/ffba_seq.sv
rtl/first_fit_block_allocator_core.sv
bench/first_fit_block_allocator_core_tb.sv
